// ===== hw/rtl/diff_drive_odometry_defines.svh =====
// Assertion macros shared by the odometry checker.
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH

// Same-cycle implication, held off during reset
`define DDO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define DDO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ddo_pkg.sv =====
// Shared types, constants and helper functions of the odometry block.
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int FRAC_BITS_DEF    = 16;

    // Register reset values
    localparam logic [31:0] RPM_SCALE_RST   = 32'd1124420;
    localparam logic [31:0] PULSE_SCALE_RST = 32'd2248840;
    localparam logic [31:0] INV_SEP_RST     = 32'd236592;

    // CORDIC start gain in Q2.30, and 1/(2 pi) in Q0.32
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0]        INV_TWO_PI  = 32'd683565276;

    typedef enum logic [1:0] {
        CFG_RPM_SCALE   = 2'd0,
        CFG_PULSE_SCALE = 2'd1,
        CFG_INV_SEP     = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_WB,
        S_CORDIC,
        S_DONE
    } t_state;

    // Multiplier jobs, in issue order
    typedef enum logic [3:0] {
        OP_WL,
        OP_WR,
        OP_RAD,
        OP_DTH_LO,
        OP_DTH_HI,
        OP_V,
        OP_A,
        OP_W_HI,
        OP_W_LO,
        OP_DS,
        OP_X,
        OP_Y
    } t_op;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_q30;
        logic signed [31:0] sin_q30;
    } t_cordic_res;

    // atan(2^-i) as binary angle
    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051D;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2E;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2F9;
            5'd15: a = 32'h0000517C;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A2F;
            5'd19: a = 32'h00000517;
            5'd20: a = 32'h0000028B;
            5'd21: a = 32'h00000145;
            5'd22: a = 32'h000000A2;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000028;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000002;
            5'd29: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    // Clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        if (v > 67'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -67'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ddo_mul.sv =====
// Shared registered 33x33 signed multiplier.
module ddo_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_prod
);
    logic signed [65:0] r_prod;

    // One product per cycle, result in the next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

// ===== hw/rtl/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
module ddo_cordic #(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_angle,
    output ddo_pkg::t_cordic_res o_res
);
    import ddo_pkg::*;

    localparam int          NUM  = (STEPS > 32) ? 32 : STEPS;
    localparam logic [4:0]  LAST = 5'(NUM - 1);

    logic signed [33:0] r_x, r_y, r_z;
    logic [4:0]         r_i;
    logic               r_busy, r_done, r_flip;

    logic               w_flip;
    logic [31:0]        w_ang;
    logic [31:0]        w_sum;
    logic signed [33:0] w_sh_x, w_sh_y, w_atan;

    // Fold angle into [-pi/2, pi/2) by a half turn
    always_comb begin
        w_sum  = i_angle + 32'h40000000;
        w_flip = w_sum[31];
        w_ang  = w_flip ? (i_angle ^ 32'h80000000) : i_angle;
        w_sh_x = r_x >>> r_i;
        w_sh_y = r_y >>> r_i;
        w_atan = $signed({2'b00, atan_angle(r_i)});
    end

    // Micro-rotation sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= 34'($signed(w_ang));
                r_flip <= w_flip;
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - w_sh_y;
                    r_y <= r_y + w_sh_x;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_sh_y;
                    r_y <= r_y - w_sh_x;
                    r_z <= r_z + w_atan;
                end
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 5'd1;
                end
            end
        end
    end

    // Undo the fold
    always_comb begin
        o_res.done    = r_done;
        o_res.cos_q30 = r_flip ? 32'(-r_x) : 32'(r_x);
        o_res.sin_q30 = r_flip ? 32'(-r_y) : 32'(r_y);
    end
endmodule

// ===== hw/rtl/diff_drive_odometry.sv =====
// Top level of the differential-drive wheel odometry block.
// Takes one word of wheel rpm, encoder counts and elapsed time, and returns one word with the
// updated pose (x, y in Q16.16, heading as a binary angle), linear and angular speed and an
// update flag. A sequencer runs all products through one registered 33x33 multiplier (a
// multiply state and a write-back state per product, twelve products) and the sine and cosine
// of the midpoint heading through an iterative CORDIC (min(CORDIC_STEPS, 32) rotations). The
// result word is loaded in the done state, and the next word can be taken only after that. A
// zero elapsed time skips the products and goes straight to the done state. The input is not
// ready while an item is at work; the result sits in an output register until taken, and a held
// result stalls the sequencer in its done state. Configuration writes land at once.
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_left_rpm,
    input  logic signed [15:0] i_right_rpm,
    input  logic signed [31:0] i_left_pulses,
    input  logic signed [31:0] i_right_pulses,
    input  logic [31:0]        i_elapsed,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic [31:0]        o_heading_angle,
    output logic signed [31:0] o_linear_speed,
    output logic signed [31:0] o_angular_speed,
    output logic               o_updated
);
    import ddo_pkg::*;

    localparam int SH_DIST = 32 - FRAC_BITS;
    localparam int SH_V    = 33 - FRAC_BITS;

    t_state r_state, n_state;
    t_op    r_op;

    // Configuration
    logic [31:0] r_rpm_scale, r_pulse_scale, r_inv_sep;

    // Latched input word
    logic signed [15:0] r_lr, r_rr;
    logic [31:0]        r_lp, r_rp, r_dt;
    logic               r_zero;

    // Working values
    logic [31:0]        r_left_d, r_right_d, r_diff, r_dth, r_mid, r_new_x, r_new_y;
    logic [63:0]        r_rad, r_a;
    logic signed [65:0] r_wtmp;
    logic signed [31:0] r_v, r_w, r_ds, r_cos, r_sin;
    logic               r_cstart;

    // Odometry state
    logic [31:0] r_prev_l, r_prev_r, r_x, r_y, r_head;

    // Result register
    logic               r_out_valid, r_out_upd;
    logic signed [31:0] r_out_v, r_out_w;

    logic signed [32:0] w_mul_a, w_mul_b;
    logic signed [65:0] w_prod, w_prod_f;
    logic signed [16:0] w_rpm_sum, w_rpm_diff;
    logic [31:0]        w_dist, w_dth_hi;
    logic               w_out_load;
    t_cordic_res        w_cres;

    function automatic logic [31:0] abs32(input logic [31:0] p);
        return p[31] ? (~p + 32'd1) : p;
    endfunction

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_angle (r_mid),
        .o_res   (w_cres)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm_scale   <= RPM_SCALE_RST;
            r_pulse_scale <= PULSE_SCALE_RST;
            r_inv_sep     <= INV_SEP_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RPM_SCALE:   r_rpm_scale   <= i_cfg_data;
                CFG_PULSE_SCALE: r_pulse_scale <= i_cfg_data;
                CFG_INV_SEP:     r_inv_sep     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_elapsed == 32'd0) ? S_DONE : S_MUL;
                end
            end
            S_MUL: n_state = S_WB;
            S_WB: begin
                if (r_op == OP_DS) begin
                    n_state = S_CORDIC;
                end else if (r_op == OP_Y) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_CORDIC: begin
                if (w_cres.done) begin
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Multiplier operand select
    always_comb begin
        w_rpm_sum  = 17'(r_lr) + 17'(r_rr);
        w_rpm_diff = 17'(r_rr) - 17'(r_lr);
        w_mul_a    = '0;
        w_mul_b    = '0;
        case (r_op)
            OP_WL: begin
                w_mul_a = $signed({1'b0, abs32(r_lp)});
                w_mul_b = $signed({1'b0, r_pulse_scale});
            end
            OP_WR: begin
                w_mul_a = $signed({1'b0, abs32(r_rp)});
                w_mul_b = $signed({1'b0, r_pulse_scale});
            end
            OP_RAD: begin
                w_mul_a = 33'($signed(r_diff));
                w_mul_b = $signed({1'b0, r_inv_sep});
            end
            OP_DTH_LO: begin
                w_mul_a = $signed({1'b0, r_rad[31:0]});
                w_mul_b = $signed({1'b0, INV_TWO_PI});
            end
            OP_DTH_HI: begin
                w_mul_a = $signed({1'b0, r_rad[63:32]});
                w_mul_b = $signed({1'b0, INV_TWO_PI});
            end
            OP_V: begin
                w_mul_a = 33'(w_rpm_sum);
                w_mul_b = $signed({1'b0, r_rpm_scale});
            end
            OP_A: begin
                w_mul_a = 33'(w_rpm_diff);
                w_mul_b = $signed({1'b0, r_rpm_scale});
            end
            OP_W_HI: begin
                w_mul_a = 33'($signed(r_a[63:32]));
                w_mul_b = $signed({1'b0, r_inv_sep});
            end
            OP_W_LO: begin
                w_mul_a = $signed({1'b0, r_a[31:0]});
                w_mul_b = $signed({1'b0, r_inv_sep});
            end
            OP_DS: begin
                w_mul_a = $signed({1'b0, r_dt});
                w_mul_b = 33'(r_v);
            end
            OP_X: begin
                w_mul_a = 33'(r_ds);
                w_mul_b = 33'(r_cos);
            end
            OP_Y: begin
                w_mul_a = 33'(r_ds);
                w_mul_b = 33'(r_sin);
            end
            default: ;
        endcase
    end

    // Product shifts used at write-back
    always_comb begin
        w_prod_f = w_prod >>> FRAC_BITS;
        w_dist   = 32'(w_prod >>> SH_DIST);
        w_dth_hi = r_dth + (w_prod[31:0] << SH_DIST);
    end

    // Input latch, write-back and sequencing of the jobs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_WL;
            r_cstart <= 1'b0;
        end else begin
            r_cstart <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_lr   <= i_left_rpm;
                        r_rr   <= i_right_rpm;
                        r_lp   <= i_left_pulses;
                        r_rp   <= i_right_pulses;
                        r_dt   <= i_elapsed;
                        r_zero <= (i_elapsed == 32'd0);
                        r_op   <= OP_WL;
                    end
                end
                S_WB: begin
                    if (r_op != OP_Y) begin
                        r_op <= t_op'(r_op + 4'd1);
                    end
                    case (r_op)
                        OP_WL:     r_left_d <= 32'd0 - w_dist;
                        OP_WR: begin
                            r_right_d <= w_dist;
                            r_diff    <= (w_dist - r_prev_r) - (r_left_d - r_prev_l);
                        end
                        OP_RAD:    r_rad <= 64'(w_prod_f);
                        OP_DTH_LO: r_dth <= 32'(w_prod_f);
                        OP_DTH_HI: begin
                            r_dth <= w_dth_hi;
                            r_mid <= r_head + {w_dth_hi[31], w_dth_hi[31:1]};
                        end
                        OP_V:      r_v <= sat32(67'(w_prod >>> SH_V));
                        OP_A:      r_a <= w_prod[63:0];
                        OP_W_HI:   r_wtmp <= w_prod;
                        OP_W_LO:   r_w <= sat32(67'(r_wtmp) + 67'($signed({1'b0, w_prod[63:32]})));
                        OP_DS: begin
                            r_ds     <= sat32(67'(w_prod_f));
                            r_cstart <= 1'b1;
                        end
                        OP_X:      r_new_x <= r_x + 32'(w_prod >>> 30);
                        OP_Y:      r_new_y <= r_y + 32'(w_prod >>> 30);
                        default: ;
                    endcase
                end
                S_CORDIC: begin
                    if (w_cres.done) begin
                        r_cos <= w_cres.cos_q30;
                        r_sin <= w_cres.sin_q30;
                    end
                end
                default: ;
            endcase
        end
    end

    // Commit state and load the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_upd   <= 1'b0;
            r_out_v     <= '0;
            r_out_w     <= '0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_head      <= '0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
            if (r_zero) begin
                r_out_upd <= 1'b0;
                r_out_v   <= '0;
                r_out_w   <= '0;
            end else begin
                r_out_upd <= 1'b1;
                r_out_v   <= r_v;
                r_out_w   <= r_w;
                r_prev_l  <= r_left_d;
                r_prev_r  <= r_right_d;
                r_x       <= r_new_x;
                r_y       <= r_new_y;
                r_head    <= r_head + r_dth;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pose_x        = r_x;
    assign o_pose_y        = r_y;
    assign o_heading_angle = r_head;
    assign o_linear_speed  = r_out_v;
    assign o_angular_speed = r_out_w;
    assign o_updated       = r_out_upd;
endmodule

// ===== hw/rtl/ddo_checker.sv =====
// Port-level checker for the odometry block, with its bind.
`include "diff_drive_odometry_defines.svh"

module ddo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_pose_x,
    input logic signed [31:0] o_pose_y,
    input logic [31:0]        o_heading_angle,
    input logic signed [31:0] o_linear_speed,
    input logic signed [31:0] o_angular_speed,
    input logic               o_updated
);
    logic [160:0] w_payload, r_payload;
    logic         w_stall, w_take, w_held, w_zero_spd;

    // Whole result word, and a registered copy of it
    assign w_payload = {o_pose_x, o_pose_y, o_heading_angle, o_linear_speed,
                        o_angular_speed, o_updated};

    always_ff @(posedge i_clk) begin
        r_payload <= w_payload;
    end

    assign w_stall    = o_out_valid && !i_out_ready;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_held     = o_out_valid && (w_payload == r_payload);
    assign w_zero_spd = (o_linear_speed == 32'sd0) && (o_angular_speed == 32'sd0);

    // Stalled result word holds
    `DDO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, w_held, "result word changed while stalled")

    // One word at a time: busy after an accept
    `DDO_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_take, !o_in_ready, "input taken while busy")

    // No update means zero speeds
    `DDO_ASSERT_NOW(a_idle_speeds, i_clk, i_rst_n, o_out_valid && !o_updated, w_zero_spd, "speeds nonzero")
endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the differential-drive wheel odometry block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ddo_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;   // no register behind this index
    localparam int FRAC = 16;
    localparam int STEPS = 24;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [15:0] left_rpm;
        logic signed [15:0] right_rpm;
        logic signed [31:0] left_pulses;
        logic signed [31:0] right_pulses;
        logic [31:0]        elapsed;
    } t_odo_word;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic [31:0]        heading;
        logic signed [31:0] lin;
        logic signed [31:0] ang;
        logic               updated;
    } t_pose_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [1:0] i_cfg_index = CFG_RPM_SCALE;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_odo_word drv_word = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [31:0] o_pose_x, o_pose_y, o_linear_speed, o_angular_speed;
    logic [31:0] o_heading_angle;
    logic o_updated;

    diff_drive_odometry dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_left_rpm(drv_word.left_rpm), .i_right_rpm(drv_word.right_rpm),
        .i_left_pulses(drv_word.left_pulses), .i_right_pulses(drv_word.right_pulses),
        .i_elapsed(drv_word.elapsed),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_pose_x(o_pose_x), .o_pose_y(o_pose_y), .o_heading_angle(o_heading_angle),
        .o_linear_speed(o_linear_speed), .o_angular_speed(o_angular_speed),
        .o_updated(o_updated)
    );

    always #5 i_clk = ~i_clk;

    // Scoreboard state
    t_odo_word  pending_words[$];
    t_pose_word pose_expected[$];
    int errors = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    // Shadow registers and odometry state
    logic [31:0] rpm_scale, pulse_scale, inv_sep;
    logic [31:0] prev_left, prev_right, acc_x, acc_y, acc_heading;

    // Encoder positions for well-formed random sequences
    logic signed [31:0] enc_left = '0, enc_right = '0;

    logic [31:0] atan_lut [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -96'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Encoder magnitude scaled to metres
    function automatic logic [31:0] pulses_to_metres(input logic signed [31:0] p);
        logic [32:0] mag;
        logic [64:0] prod;
        mag = p[31] ? 33'h100000000 - {1'b0, p} : {1'b0, p};
        prod = mag * pulse_scale;
        return prod[63-FRAC -: 32];
    endfunction

    // Rotation-mode CORDIC of a binary angle, Q2.30 outputs
    task automatic rotate_unit(input logic [31:0] ang, output logic signed [63:0] c,
                               output logic signed [63:0] s);
        logic flip;
        logic [31:0] a;
        logic signed [63:0] x, y, z, nx;
        a = ang + 32'h40000000;
        flip = a[31];
        a = flip ? ang ^ 32'h80000000 : ang;
        x = 64'(CORDIC_GAIN);
        y = 0;
        z = 64'(signed'(a));
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - 64'(atan_lut[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + 64'(atan_lut[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Advance the odometry by one word and queue the pose it should produce
    task automatic odo_advance(input t_odo_word w);
        t_pose_word r;
        logic [31:0] ld, rd, dth, half, mid;
        logic signed [95:0] diff, rad, rs, iv, prod;
        logic [63:0] rad_turn;
        logic signed [31:0] v, ang, ds;
        logic signed [63:0] c, s;
        if (w.elapsed == 0) begin
            r = '{acc_x, acc_y, acc_heading, 32'sd0, 32'sd0, 1'b0};
            pose_expected.push_back(r);
            return;
        end
        ld = -pulses_to_metres(w.left_pulses);
        rd = pulses_to_metres(w.right_pulses);
        diff = 96'(signed'((rd - prev_right) - (ld - prev_left)));
        iv = {64'd0, inv_sep};
        rs = {64'd0, rpm_scale};
        rad = (diff * iv) >>> FRAC;
        rad_turn = rad[63:0] * 64'(INV_TWO_PI);
        dth = rad_turn[FRAC+31 -: 32];
        prod = (96'(w.left_rpm) + 96'(w.right_rpm)) * rs;
        v = clamp32(prod >>> (33 - FRAC));
        prod = (96'(w.right_rpm) - 96'(w.left_rpm)) * rs * iv;
        ang = clamp32(prod >>> 32);
        prod = {64'd0, w.elapsed} * 96'(v);
        ds = clamp32(prod >>> FRAC);
        half = {dth[31], dth[31:1]};
        mid = acc_heading + half;
        acc_heading = acc_heading + dth;
        rotate_unit(mid, c, s);
        acc_x = acc_x + 32'((64'(ds) * c) >>> 30);
        acc_y = acc_y + 32'((64'(ds) * s) >>> 30);
        prev_left = ld;
        prev_right = rd;
        r = '{acc_x, acc_y, acc_heading, v, ang, 1'b1};
        pose_expected.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= 30)
            $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
    endtask

    // Driver: present queued words, accept on handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) odo_advance(drv_word);
            if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                drv_word <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, compare each taken word
    always @(posedge i_clk) begin
        t_pose_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pose_expected.size() == 0) begin
                report_mismatch("unexpected word, updated", 32'(o_updated), 32'd0);
            end else begin
                e = pose_expected.pop_front();
                if (o_pose_x !== e.pose_x) report_mismatch("pose_x", o_pose_x, e.pose_x);
                if (o_pose_y !== e.pose_y) report_mismatch("pose_y", o_pose_y, e.pose_y);
                if (o_heading_angle !== e.heading)
                    report_mismatch("heading", o_heading_angle, e.heading);
                if (o_linear_speed !== e.lin)
                    report_mismatch("linear_speed", o_linear_speed, e.lin);
                if (o_angular_speed !== e.ang)
                    report_mismatch("angular_speed", o_angular_speed, e.ang);
                if (o_updated !== e.updated)
                    report_mismatch("updated", 32'(o_updated), 32'(e.updated));
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_in_valid || pose_expected.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_RPM_SCALE:   rpm_scale = val;
            CFG_PULSE_SCALE: pulse_scale = val;
            CFG_INV_SEP:     inv_sep = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic push_word(input logic signed [15:0] lr, input logic signed [15:0] rr,
                             input logic signed [31:0] lp, input logic signed [31:0] rp,
                             input logic [31:0] dt);
        t_odo_word w;
        w = '{lr, rr, lp, rp, dt};
        pending_words.push_back(w);
    endtask

    function automatic logic [31:0] rand_step();
        int k;
        k = $urandom_range(99);
        if (k < 6) return 32'd0;
        if (k < 70) return $urandom_range(32'h00030000, 1);
        if (k < 80) return 32'hFFFFFFFF;
        return $urandom;
    endfunction

    function automatic logic [15:0] rand_rpm();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(600)) - 300);
    endfunction

    // Random words: mostly smooth encoder motion, some noise
    task automatic push_random(input int n);
        logic signed [31:0] lp, rp;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 80) begin
                enc_left = enc_left + 32'($signed($urandom_range(4000)) - 2000);
                enc_right = enc_right + 32'($signed($urandom_range(4000)) - 2000);
                lp = enc_left;
                rp = enc_right;
            end else begin
                lp = $urandom;
                rp = $urandom;
            end
            push_word(rand_rpm(), rand_rpm(), lp, rp, rand_step());
        end
    endtask

    initial begin
        rpm_scale = RPM_SCALE_RST;
        pulse_scale = PULSE_SCALE_RST;
        inv_sep = INV_SEP_RST;
        prev_left = '0; prev_right = '0;
        acc_x = '0; acc_y = '0; acc_heading = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed: reset scales, edges of each field, zero elapsed time
        push_word(16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'd0);
        push_word(16'sd100, 16'sd100, 32'sd1000, 32'sd1000, 32'h00010000);
        push_word(16'sd100, 16'sd100, 32'sd1000, 32'sd1000, 32'h00010000);
        push_word(-16'sd200, 16'sd200, -32'sd5000, 32'sd5000, 32'h00008000);
        push_word(16'sh7FFF, 16'sh7FFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'hFFFFFFFF);
        push_word(16'sh8000, 16'sh8000, 32'sh80000000, 32'sh80000000, 32'hFFFFFFFF);
        push_word(16'sh8000, 16'sh7FFF, 32'sh80000000, 32'sh7FFFFFFF, 32'h00000001);
        push_word(16'sh7FFF, 16'sh8000, 32'sh7FFFFFFF, 32'sh80000000, 32'h00020000);
        push_word(16'sh7FFF, 16'sh8000, 32'sh12345678, -32'sd77, 32'd0);
        push_word(16'sd50, -16'sd50, 32'sd0, 32'sd40000, 32'h00004000);
        push_word(-16'sd1, -16'sd1, -32'sd1, -32'sd1, 32'h80000000);
        push_word(16'sd1, 16'sd1, 32'sd1, 32'sd1, 32'h7FFFFFFF);
        wait_drained();

        // Unmapped index must leave everything alone
        cfg_write(CFG_UNUSED, 32'hDEADBEEF);
        push_word(16'sd300, -16'sd120, 32'sd9000, 32'sd12000, 32'h00010000);
        wait_drained();

        // Extreme scales
        cfg_write(CFG_RPM_SCALE, 32'hFFFFFFFF);
        cfg_write(CFG_PULSE_SCALE, 32'hFFFFFFFF);
        cfg_write(CFG_INV_SEP, 32'hFFFFFFFF);
        push_word(16'sh7FFF, 16'sh8000, 32'sh80000000, 32'sh7FFFFFFF, 32'hFFFFFFFF);
        push_word(16'sh8000, 16'sh7FFF, 32'sh7FFFFFFF, 32'sh80000000, 32'h00010000);
        push_random(40);
        wait_drained();
        cfg_write(CFG_RPM_SCALE, 32'd0);
        cfg_write(CFG_PULSE_SCALE, 32'd0);
        cfg_write(CFG_INV_SEP, 32'd0);
        push_word(16'sd500, 16'sd700, 32'sd100, 32'sd300, 32'h00010000);
        push_random(40);
        wait_drained();

        // Random phases over the idling mixes and several scale settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (ph == 0) begin
                cfg_write(CFG_RPM_SCALE, RPM_SCALE_RST);
                cfg_write(CFG_PULSE_SCALE, PULSE_SCALE_RST);
                cfg_write(CFG_INV_SEP, INV_SEP_RST);
            end else if (ph == 4) begin
                cfg_write(CFG_RPM_SCALE, $urandom);
                cfg_write(CFG_PULSE_SCALE, $urandom);
                cfg_write(CFG_INV_SEP, $urandom);
            end else if (ph % 2 == 1) begin
                cfg_write(CFG_RPM_SCALE, $urandom_range(32'h00400000));
                cfg_write(CFG_PULSE_SCALE, $urandom_range(32'h00400000));
                cfg_write(CFG_INV_SEP, $urandom_range(32'h00080000));
                cfg_write(CFG_UNUSED, $urandom);
            end
            push_random(105);
            wait_drained();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
